@@ rtl/phv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package phv_pkg;

  localparam int BINS        = 256;
  localparam int BIN_BITS    = $clog2(BINS);
  localparam int COUNT_BITS  = 16;
  localparam int ROW_W       = 20;
  localparam int FRAC_BITS   = 4;
  localparam int FRAME_W     = 16;
  localparam int SCORE_W     = 50;
  localparam int OUT_COUNT_W = 16;

  localparam int DIV_W    = FRAME_W + FRAC_BITS;
  localparam int REM_W    = DIV_W + BIN_BITS;
  localparam int STEP_W   = $clog2(BIN_BITS);
  localparam int SCALED_W = COUNT_BITS + BIN_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(1024);
  localparam logic [63:0]        ROOT_LIMIT  = 64'd33554431;

  typedef struct packed {
    logic signed [ROW_W-1:0] point_row;
    logic                    last_point;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0]     spread_score;
    logic [OUT_COUNT_W-1:0] peak_bin_count;
    logic [OUT_COUNT_W-1:0] total_points;
  } out_item_t;

  typedef struct packed {
    logic [BIN_BITS-1:0] bin;
    logic                last;
  } task_t;

  typedef enum logic [1:0] {
    ST_F_IDLE,
    ST_F_DIV,
    ST_F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    ST_B_IDLE,
    ST_B_UPD,
    ST_B_SWEEP,
    ST_B_DRAIN
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/phv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module phv_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pt_valid,
  output logic                         pt_ready,
  input  phv_pkg::in_item_t            point,
  input  logic [phv_pkg::FRAME_W-1:0]  frame_size,
  output logic                         push_valid,
  input  logic                         push_ready,
  output phv_pkg::task_t               push_item
);
  import phv_pkg::*;

  front_state_t state, state_next;

  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dsh;
  logic [BIN_BITS-1:0] quo;
  logic [STEP_W-1:0]   step;
  logic                last;

  logic [FRAME_W-1:0] fs_eff;
  logic [DIV_W-1:0]   divisor;
  logic [REM_W-1:0]   dividend;
  logic [REM_W-1:0]   limit;
  logic               neg;
  logic               clamp;
  logic               accept;
  logic               ge;

  assign fs_eff   = (frame_size == '0) ? FRAME_W'(1) : frame_size;
  assign divisor  = {fs_eff, {FRAC_BITS{1'b0}}};
  assign dividend = REM_W'(point.point_row[ROW_W-2:0]) << BIN_BITS;
  assign limit    = REM_W'(divisor) << BIN_BITS;
  assign neg      = point.point_row[ROW_W-1];
  assign clamp    = dividend >= limit;
  assign ge       = rem >= dsh;
  assign accept   = pt_valid && pt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pt_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      ST_F_IDLE: begin
        pt_ready = 1'b1;
        if (pt_valid) begin
          state_next = (neg || clamp) ? ST_F_PUSH : ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        if (step == '0) begin
          state_next = ST_F_PUSH;
        end
      end
      ST_F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = ST_F_IDLE;
        end
      end
      default: begin
        state_next = ST_F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last <= point.last_point;
      rem  <= dividend;
      dsh  <= REM_W'(divisor) << (BIN_BITS - 1);
      step <= STEP_W'(BIN_BITS - 1);
      if (neg) begin
        quo <= '0;
      end else if (clamp) begin
        quo <= BIN_BITS'(BINS - 1);
      end else begin
        quo <= '0;
      end
    end else if (state == ST_F_DIV) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[BIN_BITS-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - STEP_W'(1);
    end
  end

  assign push_item = '{bin: quo, last: last};

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_F_DIV |-> (rem >> 1) < dsh)
    else $error("division remainder out of bound");

endmodule

`default_nettype wire

@@ rtl/phv_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module phv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  phv_pkg::task_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output phv_pkg::task_t pop_item
);
  import phv_pkg::*;

  task_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/phv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module phv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              task_valid,
  output logic              task_ready,
  input  phv_pkg::task_t    task_item,
  output logic              res_valid,
  input  logic              res_ready,
  output phv_pkg::out_item_t result
);
  import phv_pkg::*;

  back_state_t state, state_next;

  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rdata;
  logic [BINS-1:0]       bin_valid;
  logic [BIN_BITS-1:0]   cur_bin;
  logic                  cur_last;
  logic [BIN_BITS-1:0]   sweep_idx;
  logic [BIN_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] n_count;

  logic                  s1_v;
  logic                  s1_bv;
  logic                  s2_v;
  logic                  s2_nz;
  logic [SCALED_W-1:0]   s2_diff;
  logic                  s3_v;
  logic [SCORE_W-1:0]    s3_term;
  logic [SCORE_W-1:0]    score;
  logic [COUNT_BITS-1:0] peak;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] sw_cnt;
  logic [SCALED_W-1:0]   sw_scaled;
  logic [SCALED_W-1:0]   n_ext;
  logic [SCALED_W-1:0]   sw_diff;
  logic [2*SCALED_W-1:0] sq;
  logic                  over;
  logic [SCORE_W:0]      score_sum;
  logic                  mem_we;
  logic                  load;
  logic                  sweep_start;
  logic                  pipe_empty;

  assign cnt_cur   = bin_valid[cur_bin] ? rdata : '0;
  assign cnt_inc   = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
  assign sw_cnt    = s1_bv ? rdata : '0;
  assign sw_scaled = {sw_cnt, {BIN_BITS{1'b0}}};
  assign n_ext     = SCALED_W'(n_count);
  assign sw_diff   = (sw_scaled >= n_ext) ? sw_scaled - n_ext : n_ext - sw_scaled;
  assign sq        = s2_diff * s2_diff;
  assign over      = 64'(s2_diff) > ROOT_LIMIT;
  assign score_sum = (SCORE_W + 1)'(score) + (SCORE_W + 1)'(s3_term);
  assign pipe_empty = !s1_v && !s2_v && !s3_v;
  assign rd_addr   = (state == ST_B_SWEEP) ? sweep_idx : task_item.bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    task_ready  = 1'b0;
    mem_we      = 1'b0;
    load        = 1'b0;
    sweep_start = 1'b0;
    unique case (state)
      ST_B_IDLE: begin
        task_ready = 1'b1;
        if (task_valid) begin
          state_next = ST_B_UPD;
        end
      end
      ST_B_UPD: begin
        mem_we = 1'b1;
        if (cur_last) begin
          sweep_start = 1'b1;
          state_next  = ST_B_SWEEP;
        end else begin
          state_next = ST_B_IDLE;
        end
      end
      ST_B_SWEEP: begin
        if (sweep_idx == BIN_BITS'(BINS - 1)) begin
          state_next = ST_B_DRAIN;
        end
      end
      ST_B_DRAIN: begin
        if (pipe_empty && (!res_valid || res_ready)) begin
          load       = 1'b1;
          state_next = ST_B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_bin] <= cnt_inc;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      n_count   <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        bin_valid <= '0;
        n_count   <= '0;
      end else if (mem_we) begin
        bin_valid[cur_bin] <= 1'b1;
        if (n_count != '1) begin
          n_count <= n_count + COUNT_BITS'(1);
        end
      end
      s1_v <= state == ST_B_SWEEP;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (task_valid && task_ready) begin
      cur_bin  <= task_item.bin;
      cur_last <= task_item.last;
    end
    if (sweep_start) begin
      sweep_idx <= '0;
      score     <= '0;
      peak      <= '0;
    end else begin
      if (state == ST_B_SWEEP) begin
        sweep_idx <= sweep_idx + BIN_BITS'(1);
      end
      if (s1_v && sw_cnt > peak) begin
        peak <= sw_cnt;
      end
      if (s3_v) begin
        score <= score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
      end
    end
    if (state == ST_B_SWEEP) begin
      s1_bv <= bin_valid[sweep_idx];
    end
    s2_nz   <= sw_cnt != '0;
    s2_diff <= sw_diff;
    if (!s2_nz) begin
      s3_term <= '0;
    end else if (over) begin
      s3_term <= '1;
    end else begin
      s3_term <= SCORE_W'(sq);
    end
    if (load) begin
      result <= '{spread_score:   score,
                  peak_bin_count: OUT_COUNT_W'(peak),
                  total_points:   OUT_COUNT_W'(n_count)};
    end
  end

  a_points_cover_peak: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> result.total_points >= result.peak_bin_count)
    else $error("peak bin count exceeds point count");

  a_nonempty_set: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> result.total_points != '0)
    else $error("result for an empty set");

  a_bins_cleared: assert property (@(posedge clk) disable iff (rst)
    load |=> bin_valid == '0 && n_count == '0)
    else $error("bins not cleared after a result");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> state == ST_B_SWEEP || state == ST_B_DRAIN)
    else $error("sweep pipeline active outside a sweep");

endmodule

`default_nettype wire

@@ rtl/projection_histogram_variance_unit.sv @@
// Channel   Signals                          Direction  Carries
// point     pt_valid, pt_ready, point        in         one row coordinate and last mark
// result    res_valid, res_ready, result     out        score, peak count, point count
// config    cfg_valid, cfg_ready, cfg_data   in         frame_size
//
// The front takes no new point until the last is pushed; the bin divider does a bit a cycle.
// The back reads the bin memory port in idle and writes it back in update, for each point.
// A last point adds a sweep of all 256 bins through that port, and a drain, before the result.
// Reset is synchronous; bin contents are covered by valid bits, so no clearing pass runs.
// A stalled result holds the back part only, at its next result; the front works until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module projection_histogram_variance_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pt_valid,
  output logic                         pt_ready,
  input  phv_pkg::in_item_t            point,
  output logic                         res_valid,
  input  logic                         res_ready,
  output phv_pkg::out_item_t           result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [phv_pkg::FRAME_W-1:0]  cfg_data
);
  import phv_pkg::*;

  logic [FRAME_W-1:0] frame_size;
  logic               q_push_valid;
  logic               q_push_ready;
  task_t              q_push_item;
  logic               q_pop_valid;
  logic               q_pop_ready;
  task_t              q_pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_size <= cfg_data;
    end
  end

  phv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .point      (point),
    .frame_size (frame_size),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  phv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  phv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .task_valid (q_pop_valid),
    .task_ready (q_pop_ready),
    .task_item  (q_pop_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import phv_pkg::*;

  localparam longint unsigned SCORE_MAX = (64'd1 << SCORE_W) - 64'd1;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 125;

  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic                    last;
    logic                    typed;
    logic [SCORE_W-1:0]      score;
    logic [OUT_COUNT_W-1:0]  peak;
    logic [OUT_COUNT_W-1:0]  total;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pt_valid = 1'b0;
  logic               pt_ready;
  in_item_t           point = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  out_item_t          result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FRAME_W-1:0] cfg_data = '0;

  logic [COUNT_BITS-1:0] bin_count [BINS];
  logic [COUNT_BITS-1:0] set_points;
  logic [FRAME_W-1:0]    frame_cfg;
  out_item_t             pending_profiles [$];
  int                    errors = 0;
  bit                    no_idle = 1'b0;
  bit                    long_hold_req = 1'b0;
  bit                    long_hold_done = 1'b0;

  dir_row_t directed_rows [17] = '{
    '{20'sd0,       1'b1, 1'b1, 50'd65025,  16'd1, 16'd1},
    '{20'sh80000,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd524287,  1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'shFFFFF,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd63,      1'b1, 1'b1, 50'd647200, 16'd3, 16'd4},
    '{20'sd64,      1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd16319,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd16320,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd16384,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd32,      1'b1, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd100,     1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd200,     1'b1, 1'b1, 50'd129032, 16'd1, 16'd2},
    '{20'sd524287,  1'b1, 1'b1, 50'd65025,  16'd1, 16'd1},
    '{20'sh55555,   1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'shAAAAA,   1'b1, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd5,       1'b0, 1'b0, 50'd0,      16'd0, 16'd0},
    '{20'sd10,      1'b1, 1'b1, 50'd260100, 16'd2, 16'd2}
  };

  projection_histogram_variance_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .point     (point),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit bin_point(input in_item_t it, output out_item_t res);
    logic [ROW_W-1:0] raw;
    longint unsigned fs, idx, n, c, scaled, diff, term, score, peak;
    raw = it.point_row;
    res = '0;
    if (raw[ROW_W-1]) begin
      idx = 0;
    end else begin
      fs = (frame_cfg == '0) ? 64'd1 : 64'(frame_cfg);
      idx = (64'(raw) * 64'(BINS)) / (fs << FRAC_BITS);
      if (idx > 64'(BINS - 1)) idx = 64'(BINS - 1);
    end
    if (bin_count[idx] != '1) bin_count[idx]++;
    if (set_points != '1) set_points++;
    if (!it.last_point) return 1'b0;
    n = 64'(set_points);
    score = 0;
    peak = 0;
    for (int i = 0; i < BINS; i++) begin
      c = 64'(bin_count[i]);
      if (c != 0) begin
        scaled = c * 64'(BINS);
        diff = (scaled >= n) ? scaled - n : n - scaled;
        term = (diff > ROOT_LIMIT) ? SCORE_MAX : diff * diff;
        score = (score + term > SCORE_MAX) ? SCORE_MAX : score + term;
        if (c > peak) peak = c;
      end
      bin_count[i] = '0;
    end
    set_points = '0;
    res.spread_score   = score[SCORE_W-1:0];
    res.peak_bin_count = peak[OUT_COUNT_W-1:0];
    res.total_points   = n[OUT_COUNT_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(input logic [FRAME_W-1:0] fs);
    longint unsigned lim, top, edge_row;
    int unsigned sel;
    lim = ((fs == '0) ? 64'd1 : 64'(fs)) << FRAC_BITS;
    top = (lim > 64'd524288) ? 64'd524287 : lim - 64'd1;
    sel = $urandom_range(0, 99);
    if (sel < 60) return ROW_W'($urandom_range(0, 32'(top)));
    if (sel < 70) begin
      edge_row = (64'($urandom_range(1, BINS - 1)) * lim) >> BIN_BITS;
      if (edge_row <= 64'd524287) return ROW_W'(edge_row - 64'($urandom_range(0, 1)));
    end
    if (sel < 80) return {1'b1, (ROW_W-1)'($urandom)};
    if (sel < 90 && lim <= 64'd524287) return ROW_W'($urandom_range(32'(lim), 524287));
    return ROW_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_point(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t pred;
    while (!no_idle && $urandom_range(0, 99) < 18) begin
      pt_valid <= 1'b0;
      @(posedge clk);
    end
    pt_valid <= 1'b1;
    point <= it;
    do @(posedge clk); while (!pt_ready);
    if (bin_point(it, pred))
      pending_profiles.insert(pending_profiles.size(), typed ? typed_res : pred);
  endtask

  task automatic set_frame_size(input logic [FRAME_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_cfg = v;
  endtask

  task automatic settle();
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_profiles.size() == 0) begin
        report_mismatch("result with nothing pending, spread_score", result.spread_score, 0);
      end else begin
        want = pending_profiles.pop_front();
        if (result.spread_score !== want.spread_score)
          report_mismatch("spread_score", result.spread_score, want.spread_score);
        if (result.peak_bin_count !== want.peak_bin_count)
          report_mismatch("peak_bin_count", result.peak_bin_count, want.peak_bin_count);
        if (result.total_points !== want.total_points)
          report_mismatch("total_points", result.total_points, want.total_points);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        res_ready <= no_idle || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_item_t           it;
    out_item_t          typed_res;
    logic [FRAME_W-1:0] frames [RANDOM_PHASES];
    int                 phase_items;
    int                 set_len;
    foreach (bin_count[i]) bin_count[i] = '0;
    set_points = '0;
    frame_cfg = FRAME_RESET;
    frames = '{16'd1024, 16'd1, 16'd0, 16'hFFFF, 16'd640, 16'd0, 16'd2};
    frames[5] = FRAME_W'($urandom_range(0, 65535));
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      it.point_row = directed_rows[k].row;
      it.last_point = directed_rows[k].last;
      typed_res.spread_score = directed_rows[k].score;
      typed_res.peak_bin_count = directed_rows[k].peak;
      typed_res.total_points = directed_rows[k].total;
      send_point(it, directed_rows[k].typed, typed_res);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pt_valid <= 1'b0;
      settle();
      set_frame_size(frames[p]);
      no_idle = (p == 0);
      if (p == 3) long_hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (p == 3) set_len = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) set_len = 1;
        else set_len = $urandom_range(2, 30);
        for (int j = 0; j < set_len; j++) begin
          it.point_row = pick_row(frame_cfg);
          it.last_point = (j == set_len - 1);
          send_point(it, 1'b0, '0);
        end
        phase_items += set_len;
      end
    end

    pt_valid <= 1'b0;
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
